// ===== rtl/fbsba_pkg.sv =====
`default_nettype none
// ============================================================================
// fbsba_pkg
// Shared widths, defaults and pixel payload type for the fit-box scaled blit
// address generator.
// ============================================================================
package fbsba_pkg;

    // field widths
    localparam int POS_W     = 10;
    localparam int TEX_W     = 11;
    localparam int ID_W      = 16;
    localparam int BOX_IDX_W = 6;
    localparam int FA_W      = 17;
    localparam int TO_W      = 20;

    // fixed point fraction bits of the scale steps
    localparam int FRAC_W = 10;

    // stream widths
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 56;

    // parameter defaults
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;
    localparam int BOX_SIZE_DEF      = 64;
    localparam int MAX_TEX_DIM_DEF   = 1024;

    // per pixel payload carried along the pipeline
    typedef struct packed {
        logic                 ok;
        logic                 w_gt_h;
        logic [TEX_W-1:0]     w;
        logic [TEX_W-1:0]     h;
        logic [ID_W-1:0]      tid;
        logic [BOX_IDX_W-1:0] col;
        logic [BOX_IDX_W-1:0] row;
        logic [POS_W-1:0]     sx;
        logic [POS_W-1:0]     sy;
    } pix_t;

endpackage

`default_nettype wire

// ===== rtl/fbsba_div.sv =====
`default_nettype none
// ============================================================================
// fbsba_div
// Pipelined restoring divider, one quotient bit per register stage. The
// quotient comes from the last stage; stages advance only while en is high.
// Operands must satisfy dividend < divisor * 2**QUO_W.
// ============================================================================
module fbsba_div
    import fbsba_pkg::*;
#(
    parameter int DVD_W = 21,
    parameter int DVS_W = 11,
    parameter int QUO_W = 11
)
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output      logic [QUO_W-1:0] quotient
);

    localparam int CMP_W = DVS_W + QUO_W;

    logic [DVD_W-1:0] rem_reg [QUO_W-1];
    logic [DVS_W-1:0] dvs_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    // one stage per quotient bit, most significant bit first
    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - k;

        logic [DVD_W-1:0] rem_in;
        logic [DVS_W-1:0] dvs_in;
        logic [QUO_W-1:0] quo_in;
        logic [CMP_W-1:0] shifted;
        logic [CMP_W-1:0] diff;
        logic             take;
        logic [QUO_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = dividend;
            assign dvs_in = divisor;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // trial subtract of the shifted divisor
        assign shifted = CMP_W'(dvs_in) << BIT;
        assign diff    = CMP_W'(rem_in) - shifted;
        assign take    = (CMP_W'(rem_in) >= shifted);

        always_comb
        begin
            quo_next      = quo_in;
            quo_next[BIT] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[k] <= quo_next;
            end
        end

        if (k < QUO_W - 1)
        begin : g_carry
            logic [DVD_W-1:0] rem_next;

            assign rem_next = take ? diff[DVD_W-1:0] : rem_in;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    end

    assign quotient = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/fit_box_scaled_blit_address.sv =====
`default_nettype none
// ============================================================================
// fit_box_scaled_blit_address
// Per pixel address generator for a nearest neighbor blit of a texture fitted
// into a square box with its aspect ratio kept.
// ============================================================================
// One transaction is taken every clock cycle unless the output stalls. Its
// result passes the stage 1, fit divider, stage 2, step divider, stage 3 and
// output registers; the two bit-per-stage dividers set the depth. The first
// finds the short side ratio, the second, doubled for both axes, finds the
// texel steps. A stall on the output side holds the whole pipeline, and no
// result is lost or repeated. Pixels outside the fitted box, off screen, or
// of a texture with a side of zero or above MAX_TEX_DIM come out with visible
// low and zero addresses; the texture handle is always passed through.
module fit_box_scaled_blit_address
    import fbsba_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int BOX_SIZE      = BOX_SIZE_DEF,
    parameter int MAX_TEX_DIM   = MAX_TEX_DIM_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output      logic                s_axis_tready,
    // pos_x, pos_y, tex_width, tex_height, texture_id, box_col, box_row
    input  wire logic [S_DATA_W-1:0] s_axis_tdata,
    output      logic                m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // frame_address, texel_offset, texture_out
    output      logic [M_DATA_W-1:0] m_axis_tdata,
    // visible
    output      logic [0:0]          m_axis_tuser
);

    localparam int BOX_W = $clog2(BOX_SIZE + 1);
    localparam int Q1_W  = FRAC_W + 1;
    localparam int DVD_W = TEX_W + FRAC_W;
    localparam int QS_W  = DVD_W;
    localparam int FIT_W = Q1_W + BOX_W;
    localparam int TC_W  = BOX_IDX_W + QS_W - FRAC_W;
    localparam int TP_W  = TC_W + TEX_W;

    logic en;

    // input fields
    logic [POS_W-1:0]     in_px;
    logic [POS_W-1:0]     in_py;
    logic [TEX_W-1:0]     in_w;
    logic [TEX_W-1:0]     in_h;
    logic [ID_W-1:0]      in_tid;
    logic [BOX_IDX_W-1:0] in_col;
    logic [BOX_IDX_W-1:0] in_row;

    // stage 1
    logic [POS_W:0]   sx_full;
    logic [POS_W:0]   sy_full;
    logic             tex_ok;
    logic             on_screen;
    pix_t             s1_pix_next;
    logic [DVD_W-1:0] s1_dvd_next;
    logic [TEX_W-1:0] s1_dvs_next;
    logic             s1_vld_reg;
    pix_t             s1_pix_reg;
    logic [DVD_W-1:0] s1_dvd_reg;
    logic [TEX_W-1:0] s1_dvs_reg;

    // fit divider alignment
    logic [Q1_W-1:0] q1;
    logic [Q1_W-1:0] d1_vld_reg;
    pix_t            d1_pix_reg [Q1_W];
    pix_t            d1_pix;

    // stage 2
    logic [FIT_W-1:0] fit_prod;
    logic [BOX_W-1:0] fit_raw;
    logic [BOX_W-1:0] fit_short;
    logic [BOX_W-1:0] fw;
    logic [BOX_W-1:0] fh;
    logic             in_box;
    pix_t             s2_pix_next;
    logic             s2_vld_reg;
    pix_t             s2_pix_reg;
    logic [DVD_W-1:0] s2_dvdx_reg;
    logic [DVD_W-1:0] s2_dvdy_reg;
    logic [BOX_W-1:0] s2_dvsx_reg;
    logic [BOX_W-1:0] s2_dvsy_reg;

    // step divider alignment
    logic [QS_W-1:0] stepx;
    logic [QS_W-1:0] stepy;
    logic [QS_W-1:0] d2_vld_reg;
    pix_t            d2_pix_reg [QS_W];
    pix_t            d2_pix;

    // stage 3
    logic [BOX_IDX_W+QS_W-1:0] tcol_prod;
    logic [BOX_IDX_W+QS_W-1:0] trow_prod;
    logic [FA_W-1:0]           fprod_next;
    logic                      s3_vld_reg;
    pix_t                      s3_pix_reg;
    logic [TC_W-1:0]           s3_tcol_reg;
    logic [TC_W-1:0]           s3_trow_reg;
    logic [FA_W-1:0]           s3_fprod_reg;

    // output stage
    logic [TP_W-1:0] toff_full;
    logic [TO_W-1:0] out_toff_next;
    logic [FA_W-1:0] out_faddr_next;
    logic            out_vld_reg;
    logic            out_vis_reg;
    logic [FA_W-1:0] out_faddr_reg;
    logic [TO_W-1:0] out_toff_reg;
    logic [ID_W-1:0] out_tid_reg;

    // whole pipeline moves unless a held result waits
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // unpack the input transaction
    assign in_px  = s_axis_tdata[9:0];
    assign in_py  = s_axis_tdata[19:10];
    assign in_w   = s_axis_tdata[30:20];
    assign in_h   = s_axis_tdata[41:31];
    assign in_tid = s_axis_tdata[57:42];
    assign in_col = s_axis_tdata[63:58];
    assign in_row = s_axis_tdata[69:64];

    // stage 1: texture checks, screen position, fit divider operands
    always_comb
    begin
        sx_full   = {in_px[POS_W-1], in_px} + (POS_W+1)'(in_col);
        sy_full   = {in_py[POS_W-1], in_py} + (POS_W+1)'(in_row);
        tex_ok    = (in_w != '0) && (in_h != '0)
                    && (32'(in_w) <= 32'(MAX_TEX_DIM))
                    && (32'(in_h) <= 32'(MAX_TEX_DIM));
        on_screen = !sx_full[POS_W] && (32'(sx_full[POS_W-1:0]) < 32'(SCREEN_WIDTH))
                    && !sy_full[POS_W] && (32'(sy_full[POS_W-1:0]) < 32'(SCREEN_HEIGHT));

        s1_pix_next.ok     = tex_ok && on_screen;
        s1_pix_next.w_gt_h = (in_w > in_h);
        s1_pix_next.w      = in_w;
        s1_pix_next.h      = in_h;
        s1_pix_next.tid    = in_tid;
        s1_pix_next.col    = in_col;
        s1_pix_next.row    = in_row;
        s1_pix_next.sx     = sx_full[POS_W-1:0];
        s1_pix_next.sy     = sy_full[POS_W-1:0];

        // short side over long side
        if (s1_pix_next.w_gt_h)
        begin
            s1_dvd_next = {in_h, FRAC_W'(0)};
            s1_dvs_next = in_w;
        end
        else
        begin
            s1_dvd_next = {in_w, FRAC_W'(0)};
            s1_dvs_next = in_h;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pix_reg <= s1_pix_next;
            s1_dvd_reg <= s1_dvd_next;
            s1_dvs_reg <= s1_dvs_next;
        end
    end

    // ratio of short to long side
    fbsba_div #(
        .DVD_W (DVD_W),
        .DVS_W (TEX_W),
        .QUO_W (Q1_W)
    ) u_div_fit (
        .clk      (clk),
        .en       (en),
        .dividend (s1_dvd_reg),
        .divisor  (s1_dvs_reg),
        .quotient (q1)
    );

    // payload delay matching the fit divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_pix_reg[0] <= s1_pix_reg;
            for (int k = 1; k < Q1_W; k++)
            begin
                d1_pix_reg[k] <= d1_pix_reg[k-1];
            end
        end
    end

    assign d1_pix = d1_pix_reg[Q1_W-1];

    // stage 2: fitted sides, box test, step divider operands
    always_comb
    begin
        fit_prod  = FIT_W'(q1) * FIT_W'(BOX_SIZE);
        fit_raw   = fit_prod[FRAC_W +: BOX_W];
        // a fitted side that rounds to nothing still gets one pixel
        fit_short = (fit_raw == '0) ? BOX_W'(1) : fit_raw;
        fw        = d1_pix.w_gt_h ? BOX_W'(BOX_SIZE) : fit_short;
        fh        = d1_pix.w_gt_h ? fit_short : BOX_W'(BOX_SIZE);
        in_box    = (32'(d1_pix.col) < 32'(fw)) && (32'(d1_pix.row) < 32'(fh));

        s2_pix_next    = d1_pix;
        s2_pix_next.ok = d1_pix.ok && in_box;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pix_reg  <= s2_pix_next;
            s2_dvdx_reg <= {d1_pix.w, FRAC_W'(0)};
            s2_dvdy_reg <= {d1_pix.h, FRAC_W'(0)};
            s2_dvsx_reg <= fw;
            s2_dvsy_reg <= fh;
        end
    end

    // texel steps for both axes
    fbsba_div #(
        .DVD_W (DVD_W),
        .DVS_W (BOX_W),
        .QUO_W (QS_W)
    ) u_div_stepx (
        .clk      (clk),
        .en       (en),
        .dividend (s2_dvdx_reg),
        .divisor  (s2_dvsx_reg),
        .quotient (stepx)
    );

    fbsba_div #(
        .DVD_W (DVD_W),
        .DVS_W (BOX_W),
        .QUO_W (QS_W)
    ) u_div_stepy (
        .clk      (clk),
        .en       (en),
        .dividend (s2_dvdy_reg),
        .divisor  (s2_dvsy_reg),
        .quotient (stepy)
    );

    // payload delay matching the step dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_pix_reg[0] <= s2_pix_reg;
            for (int k = 1; k < QS_W; k++)
            begin
                d2_pix_reg[k] <= d2_pix_reg[k-1];
            end
        end
    end

    assign d2_pix = d2_pix_reg[QS_W-1];

    // stage 3: texel column and row, screen row offset
    always_comb
    begin
        tcol_prod  = (BOX_IDX_W+QS_W)'(d2_pix.col) * (BOX_IDX_W+QS_W)'(stepx);
        trow_prod  = (BOX_IDX_W+QS_W)'(d2_pix.row) * (BOX_IDX_W+QS_W)'(stepy);
        fprod_next = FA_W'(32'(d2_pix.sy) * 32'(SCREEN_WIDTH));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_pix_reg   <= d2_pix;
            s3_tcol_reg  <= tcol_prod[FRAC_W +: TC_W];
            s3_trow_reg  <= trow_prod[FRAC_W +: TC_W];
            s3_fprod_reg <= fprod_next;
        end
    end

    // output stage: final addresses, zero when not drawn
    always_comb
    begin
        toff_full      = TP_W'(s3_tcol_reg) * TP_W'(s3_pix_reg.h) + TP_W'(s3_trow_reg);
        out_toff_next  = s3_pix_reg.ok ? toff_full[TO_W-1:0] : '0;
        out_faddr_next = s3_pix_reg.ok ? (s3_fprod_reg + FA_W'(s3_pix_reg.sx)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_vis_reg   <= s3_pix_reg.ok;
            out_faddr_reg <= out_faddr_next;
            out_toff_reg  <= out_toff_next;
            out_tid_reg   <= s3_pix_reg.tid;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            d1_vld_reg  <= '0;
            s2_vld_reg  <= 1'b0;
            d2_vld_reg  <= '0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= s_axis_tvalid;
            d1_vld_reg  <= {d1_vld_reg[Q1_W-2:0], s1_vld_reg};
            s2_vld_reg  <= d1_vld_reg[Q1_W-1];
            d2_vld_reg  <= {d2_vld_reg[QS_W-2:0], s2_vld_reg};
            s3_vld_reg  <= d2_vld_reg[QS_W-1];
            out_vld_reg <= s3_vld_reg;
        end
    end

    // pack the result transaction
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {(M_DATA_W-FA_W-TO_W-ID_W)'(0), out_tid_reg, out_toff_reg,
                            out_faddr_reg};
    assign m_axis_tuser  = out_vis_reg;

endmodule

`default_nettype wire

// ===== sim/tb_fit_box_scaled_blit_address.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_fit_box_scaled_blit_address
// Self-checking testbench for the fit-box scaled blit address generator.
// Directed pixels cover the field extremes, aspect cases, the clamp of a fitted
// side to one pixel and invalid texture sizes. Random sprite runs follow under
// three idle patterns. Each accepted transaction is predicted at the input and
// compared field by field with the matching output transaction.
// ============================================================================
module tb_fit_box_scaled_blit_address;
    import fbsba_pkg::*;

    localparam int SCR_W    = SCREEN_WIDTH_DEF;
    localparam int SCR_H    = SCREEN_HEIGHT_DEF;
    localparam int BOX      = BOX_SIZE_DEF;
    localparam int MAX_DIM  = MAX_TEX_DIM_DEF;
    localparam int FRAC_ONE = 1 << FRAC_W;
    localparam int S_PAD_W  = S_DATA_W - (2*POS_W + 2*TEX_W + ID_W + 2*BOX_IDX_W);
    localparam int M_PAD_W  = M_DATA_W - (FA_W + TO_W + ID_W);
    localparam int RUN_ITEMS    = 440;
    localparam int DRAIN_CYCLES = 60;

    // input transaction, first field in the low bits
    typedef struct packed {
        logic [S_PAD_W-1:0]   pad;
        logic [BOX_IDX_W-1:0] box_row;
        logic [BOX_IDX_W-1:0] box_col;
        logic [ID_W-1:0]      texture_id;
        logic [TEX_W-1:0]     tex_height;
        logic [TEX_W-1:0]     tex_width;
        logic [POS_W-1:0]     pos_y;
        logic [POS_W-1:0]     pos_x;
    } blit_pixel_t;

    // output tdata layout
    typedef struct packed {
        logic [M_PAD_W-1:0] pad;
        logic [ID_W-1:0]    texture_out;
        logic [TO_W-1:0]    texel_offset;
        logic [FA_W-1:0]    frame_address;
    } blit_data_t;

    // one full result including the tuser flag
    typedef struct packed {
        logic            visible;
        logic [FA_W-1:0] frame_address;
        logic [TO_W-1:0] texel_offset;
        logic [ID_W-1:0] texture_out;
    } blit_address_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [0:0]          m_axis_tuser;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int error_count  = 0;
    blit_address_t pending_addresses[$];

    fit_box_scaled_blit_address dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("fit_box_scaled_blit_address verification failed");
        $finish;
    end

    // expected blit address of one pixel
    function automatic blit_address_t predict_blit_address(input blit_pixel_t p);
        longint px, py, w, h, col, row, fw, fh, stepx, stepy, sx, sy;
        blit_address_t a;
        a = '0;
        a.texture_out = p.texture_id;
        px  = $signed(p.pos_x);
        py  = $signed(p.pos_y);
        w   = p.tex_width;
        h   = p.tex_height;
        col = p.box_col;
        row = p.box_row;
        if (w != 0 && h != 0 && w <= MAX_DIM && h <= MAX_DIM)
        begin
            // longer side spans the box, the other is scaled in fixed point
            if (w > h)
            begin
                fw = BOX;
                fh = (((h * FRAC_ONE) / w) * BOX) / FRAC_ONE;
            end
            else
            begin
                fh = BOX;
                fw = (((w * FRAC_ONE) / h) * BOX) / FRAC_ONE;
            end
            if (fw == 0)
                fw = 1;
            if (fh == 0)
                fh = 1;
            stepx = (w * FRAC_ONE) / fw;
            stepy = (h * FRAC_ONE) / fh;
            sx = px + col;
            sy = py + row;
            if (col < fw && row < fh && sx >= 0 && sx < SCR_W && sy >= 0 && sy < SCR_H)
            begin
                a.visible       = 1'b1;
                a.frame_address = FA_W'(sx + sy * SCR_W);
                a.texel_offset  = TO_W'(((col * stepx) / FRAC_ONE) * h
                                        + (row * stepy) / FRAC_ONE);
            end
        end
        return a;
    endfunction

    function automatic blit_pixel_t make_pixel(input int x, input int y, input int w,
                                               input int h, input int id, input int col,
                                               input int row);
        blit_pixel_t p;
        p = '0;
        p.pos_x      = POS_W'(x);
        p.pos_y      = POS_W'(y);
        p.tex_width  = TEX_W'(w);
        p.tex_height = TEX_W'(h);
        p.texture_id = ID_W'(id);
        p.box_col    = BOX_IDX_W'(col);
        p.box_row    = BOX_IDX_W'(row);
        return p;
    endfunction

    // receiver back pressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // predict each accepted input transaction
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pending_addresses.push_back(predict_blit_address(blit_pixel_t'(s_axis_tdata)));
    end

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        blit_data_t    got_data;
        blit_address_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_data          = m_axis_tdata;
            got.visible       = m_axis_tuser[0];
            got.frame_address = got_data.frame_address;
            got.texel_offset  = got_data.texel_offset;
            got.texture_out   = got_data.texture_out;
            if (pending_addresses.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected transaction: vis %0d fa %0d to %0d tex %0h",
                         $time, got.visible, got.frame_address, got.texel_offset,
                         got.texture_out);
            end
            else
            begin
                want = pending_addresses.pop_front();
                if (got.visible !== want.visible)
                begin
                    error_count++;
                    $display("%0t visible: expected %0d actual %0d",
                             $time, want.visible, got.visible);
                end
                if (got.frame_address !== want.frame_address)
                begin
                    error_count++;
                    $display("%0t frame_address: expected %0d actual %0d",
                             $time, want.frame_address, got.frame_address);
                end
                if (got.texel_offset !== want.texel_offset)
                begin
                    error_count++;
                    $display("%0t texel_offset: expected %0d actual %0d",
                             $time, want.texel_offset, got.texel_offset);
                end
                if (got.texture_out !== want.texture_out)
                begin
                    error_count++;
                    $display("%0t texture_out: expected %0h actual %0h",
                             $time, want.texture_out, got.texture_out);
                end
            end
        end
    end

    // send one pixel, with random idle cycles before it
    task automatic send_pixel(input blit_pixel_t p);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // hold the sender until every predicted result has come out
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_addresses.size() != 0)
            @(posedge clk);
    endtask

    // corners of the box and screen, aspect cases, unit texture
    task automatic test_fit_extremes();
        send_pixel(make_pixel(0, 0, 64, 64, 'h0000, 0, 0));
        send_pixel(make_pixel(0, 0, 1024, 1024, 'hffff, 63, 63));
        send_pixel(make_pixel(256, 176, 64, 64, 'h1234, 63, 63));
        send_pixel(make_pixel(-512, -512, 64, 64, 'h5555, 0, 0));
        send_pixel(make_pixel(511, 511, 64, 64, 'haaaa, 0, 0));
        send_pixel(make_pixel(-63, -63, 64, 64, 'h0001, 63, 63));
        send_pixel(make_pixel(257, 177, 64, 64, 'h8000, 63, 63));
        send_pixel(make_pixel(-1, 0, 64, 64, 'h0002, 0, 5));
        send_pixel(make_pixel(0, 0, 200, 100, 'h0003, 63, 31));
        send_pixel(make_pixel(0, 0, 200, 100, 'h0004, 10, 32));
        send_pixel(make_pixel(0, 0, 100, 200, 'h0005, 31, 63));
        send_pixel(make_pixel(0, 0, 1, 1, 'h0006, 63, 63));
        send_pixel(make_pixel(0, 0, 1024, 768, 'h0007, 63, 47));
        send_pixel(make_pixel(100, 100, 3, 1000, 'h0008, 0, 40));
    endtask

    // a fitted side that rounds to zero becomes one pixel
    task automatic test_fit_clamp();
        send_pixel(make_pixel(10, 10, 1024, 1, 'h0010, 0, 0));
        send_pixel(make_pixel(10, 10, 1024, 1, 'h0011, 63, 1));
        send_pixel(make_pixel(10, 10, 1, 1024, 'h0012, 0, 5));
        send_pixel(make_pixel(10, 10, 1, 1024, 'h0013, 1, 63));
    endtask

    // zero and oversized texture sides
    task automatic test_invalid_dims();
        send_pixel(make_pixel(0, 0, 0, 64, 'h0020, 0, 0));
        send_pixel(make_pixel(0, 0, 64, 0, 'h0021, 0, 0));
        send_pixel(make_pixel(0, 0, 1025, 64, 'h0022, 0, 0));
        send_pixel(make_pixel(0, 0, 64, 2047, 'h0023, 0, 0));
        send_pixel(make_pixel(0, 0, 2047, 2047, 'h0024, 0, 0));
    endtask

    // sprite with a random texture shape and a mostly near-screen position
    function automatic blit_pixel_t random_sprite();
        int w, h;
        blit_pixel_t p;
        case ($urandom_range(5))
            0: begin w = $urandom_range(1, 1024); h = $urandom_range(1, 1024); end
            1: begin w = $urandom_range(1, 64);   h = $urandom_range(1, 64);   end
            2: begin w = $urandom_range(1, 1024); h = w;                       end
            3:
            begin
                w = $urandom_range(1, 8);
                h = $urandom_range(512, 1024);
                if ($urandom_range(1))
                begin
                    h = w;
                    w = $urandom_range(512, 1024);
                end
            end
            4: begin w = 1 << $urandom_range(10); h = 1 << $urandom_range(10); end
            default: begin w = $urandom_range(1000, 1024); h = $urandom_range(1000, 1024); end
        endcase
        p = make_pixel(int'($urandom_range(383)) - 64, int'($urandom_range(303)) - 64,
                       w, h, $urandom_range(16'hffff), 0, 0);
        if ($urandom_range(4) == 0)
        begin
            p.pos_x = POS_W'($urandom);
            p.pos_y = POS_W'($urandom);
        end
        return p;
    endfunction

    // runs of pixels of one sprite, mostly inside the fitted box, plus noise
    task automatic test_random_sprites(input int count);
        int sent, run_len, tries;
        blit_pixel_t sprite, p;
        blit_address_t probe;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                p = make_pixel($urandom, $urandom, $urandom_range(2047), $urandom_range(2047),
                               $urandom, $urandom, $urandom);
                send_pixel(p);
                sent++;
            end
            else
            begin
                sprite  = random_sprite();
                run_len = $urandom_range(4, 32);
                for (int k = 0; k < run_len; k++)
                begin
                    p = sprite;
                    for (tries = 0; tries < 6; tries++)
                    begin
                        p.box_col = BOX_IDX_W'($urandom);
                        p.box_row = BOX_IDX_W'($urandom);
                        probe     = predict_blit_address(p);
                        if (probe.visible || $urandom_range(3) == 0)
                            break;
                    end
                    send_pixel(p);
                    sent++;
                end
            end
        end
    endtask

    // test sequence
    initial
    begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        rst_n         <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles less than the receiver
        src_idle_pct = 21;
        snk_idle_pct = 45;
        test_fit_extremes();
        test_fit_clamp();
        test_invalid_dims();
        wait_results_drained();
        test_random_sprites(RUN_ITEMS);
        wait_results_drained();

        // receiver idles less than the sender
        src_idle_pct = 45;
        snk_idle_pct = 21;
        test_random_sprites(RUN_ITEMS);
        wait_results_drained();

        // full rate on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_sprites(RUN_ITEMS);
        wait_results_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("fit_box_scaled_blit_address verification clean");
        else
            $display("fit_box_scaled_blit_address verification failed");
        $finish;
    end

endmodule
